// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Holds the scan mode type, the token result record, the token kind codes
// and the byte classification functions.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_STRING = 2'd2
    } mode_t;

    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_STRING  = 5'd1;
    localparam logic [4:0] KIND_OP_BASE = 5'd2;
    localparam logic [4:0] KIND_ERROR   = 5'd19;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    // Depth of the result queue and the widths that follow from it.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] data;
        logic       has_byte;
        logic       start;
        logic       stop;
        logic       last;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t tok;
    } idle_res_t;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // Operator kind in the order + - * / ^ = > < ; : ? , | ( ) { };
    // any other byte maps to the error kind.
    function automatic logic [4:0] op_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h2B:   k = KIND_OP_BASE + 5'd0;
            8'h2D:   k = KIND_OP_BASE + 5'd1;
            8'h2A:   k = KIND_OP_BASE + 5'd2;
            8'h2F:   k = KIND_OP_BASE + 5'd3;
            8'h5E:   k = KIND_OP_BASE + 5'd4;
            8'h3D:   k = KIND_OP_BASE + 5'd5;
            8'h3E:   k = KIND_OP_BASE + 5'd6;
            8'h3C:   k = KIND_OP_BASE + 5'd7;
            8'h3B:   k = KIND_OP_BASE + 5'd8;
            8'h3A:   k = KIND_OP_BASE + 5'd9;
            8'h3F:   k = KIND_OP_BASE + 5'd10;
            8'h2C:   k = KIND_OP_BASE + 5'd11;
            8'h7C:   k = KIND_OP_BASE + 5'd12;
            8'h28:   k = KIND_OP_BASE + 5'd13;
            8'h29:   k = KIND_OP_BASE + 5'd14;
            8'h7B:   k = KIND_OP_BASE + 5'd15;
            8'h7D:   k = KIND_OP_BASE + 5'd16;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // Result of a byte seen while no token is open.
    function automatic idle_res_t idle_result(input logic [7:0] b);
        idle_res_t r;
        r.valid        = 1'b1;
        r.tok.kind     = op_kind(b);
        r.tok.data     = b;
        r.tok.has_byte = 1'b1;
        r.tok.start    = 1'b1;
        r.tok.stop     = 1'b1;
        r.tok.last     = 1'b0;
        if (b == CHAR_NUL || b == CHAR_SPACE || b == CHAR_LF) begin
            r.valid = 1'b0;
        end else if (is_alnum(b)) begin
            r.tok.kind = KIND_IDENT;
            r.tok.stop = 1'b0;
        end else if (b == CHAR_QUOTE) begin
            r.tok.kind     = KIND_STRING;
            r.tok.data     = 8'h00;
            r.tok.has_byte = 1'b0;
            r.tok.stop     = 1'b0;
        end
        return r;
    endfunction

    function automatic mode_t idle_next(input logic [7:0] b);
        mode_t m;
        if (is_alnum(b)) begin
            m = MODE_IDENT;
        end else if (b == CHAR_QUOTE) begin
            m = MODE_STRING;
        end else begin
            m = MODE_IDLE;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/stt_ifs.sv =====
// ----------------------------------------------------------------------------
// stt_ifs: channel interfaces of the source text tokenizer
// A byte channel for source text and a token channel for results, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
interface stt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface stt_token_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    logic       last_of_step;

    modport source (output valid, output token_kind, output token_byte,
                    output has_byte, output token_start, output token_end,
                    output last_of_step, input ready);
    modport sink   (input valid, input token_kind, input token_byte,
                    input has_byte, input token_start, input token_end,
                    input last_of_step, output ready);
endinterface

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer: byte-serial lexical analyzer
// Classifies one source byte per transfer and emits zero, one or two
// token results per byte through a small result queue.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one source byte per transfer; byte 0 marks the end of text.
//   tokens : one token result per transfer. A byte gives no result
//            (whitespace, end of text while idle), one result, or two
//            (a byte that closes an identifier and opens something new).
//   Latency: results are queued at their byte's transfer, offered in order.
//   Throughput: one byte per cycle while results are taken as fast as they
//   come; a byte that gives two results costs two output transfers. The
//   figure is set by the single output port of the four-entry result queue:
//   a byte is taken only while the queue has room for two results.
//   Reset: the scan mode returns to idle and the queue empties; nothing is
//   offered until a byte that gives a result is taken.
//   Stall: when tokens.ready is low the queue holds its results in order;
//   once it cannot take two more, text.ready drops until results drain.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    stt_text_if.sink           text,
    stt_token_if.source        tokens
);
    import stt_pkg::*;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    token_t                 queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   accept;
    logic                   pop;
    logic [1:0]             push_n;
    token_t                 res0;
    token_t                 res1;
    idle_res_t              idle_res;
    token_t                 head;

    // A byte is taken only when the queue can hold the two results that
    // the worst byte produces.
    assign text.ready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign accept     = text.valid && text.ready;
    assign pop        = tokens.valid && tokens.ready;

    assign idle_res = idle_result(text.text_byte);

    // Next scan mode.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                if (is_alnum(text.text_byte)) begin
                    mode_next = MODE_IDENT;
                end else begin
                    mode_next = idle_next(text.text_byte);
                end
            end
            MODE_STRING:
            begin
                if (text.text_byte == CHAR_QUOTE || text.text_byte == CHAR_NUL) begin
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = MODE_STRING;
                end
            end
            default:
            begin
                mode_next = idle_next(text.text_byte);
            end
        endcase
    end

    // Results of the current byte.
    always_comb
    begin
        res0          = idle_res.tok;
        res1          = idle_res.tok;
        push_n        = 2'd0;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                res0.kind     = KIND_IDENT;
                res0.start    = 1'b0;
                if (is_alnum(text.text_byte)) begin
                    res0.data     = text.text_byte;
                    res0.has_byte = 1'b1;
                    res0.stop     = 1'b0;
                    push_n        = 2'd1;
                end else begin
                    // End marker of the identifier, then the byte's idle result if any.
                    res0.data     = 8'h00;
                    res0.has_byte = 1'b0;
                    res0.stop     = 1'b1;
                    push_n        = idle_res.valid ? 2'd2 : 2'd1;
                end
            end
            MODE_STRING:
            begin
                res0.start = 1'b0;
                push_n     = 2'd1;
                if (text.text_byte == CHAR_QUOTE) begin
                    res0.kind     = KIND_STRING;
                    res0.data     = 8'h00;
                    res0.has_byte = 1'b0;
                    res0.stop     = 1'b1;
                end else if (text.text_byte == CHAR_NUL) begin
                    // End of text inside a string is an error.
                    res0.kind     = KIND_ERROR;
                    res0.data     = 8'h00;
                    res0.has_byte = 1'b0;
                    res0.stop     = 1'b1;
                end else begin
                    res0.kind     = KIND_STRING;
                    res0.data     = text.text_byte;
                    res0.has_byte = 1'b1;
                    res0.stop     = 1'b0;
                end
            end
            default:
            begin
                push_n = idle_res.valid ? 2'd1 : 2'd0;
            end
        endcase
        res0.last = (push_n == 2'd1);
        res1.last = 1'b1;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept) begin
            count_next = count_next + CNT_W'(push_n);
        end
        if (pop) begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                mode_reg   <= mode_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Result queue storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            if (push_n != 2'd0) begin
                queue_reg[wr_ptr_reg] <= res0;
            end
            if (push_n == 2'd2) begin
                queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
            end
        end
    end

    assign head = queue_reg[rd_ptr_reg];

    assign tokens.valid        = (count_reg != '0);
    assign tokens.token_kind   = head.kind;
    assign tokens.token_byte   = head.data;
    assign tokens.has_byte     = head.has_byte;
    assign tokens.token_start  = head.start;
    assign tokens.token_end    = head.stop;
    assign tokens.last_of_step = head.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the source text tokenizer
// Feeds source bytes into the tokenizer, predicts the token results of every
// accepted byte with its own scan mode tracker and checks each result field
// by field. A directed opening covers every operator, strings, identifiers
// and the end-of-text cases. A long random stream of token-shaped text with
// noise follows, with random gaps on both channels, one long output stall
// and one stretch at full rate.
// ----------------------------------------------------------------------------
module tb;

    import stt_pkg::*;

    // Generous cycle ceiling: about 1750 bytes at two results each, with
    // gaps on both sides and one long stall, stays far below it.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the long output stall, in cycles.
    localparam int STALL_CYCLES = 400;
    // Cycles waited after the last predicted token to catch stray results.
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_BYTES = 1750;
    localparam int NUM_OPERATORS = 17;

    logic clk;
    logic rst_n;

    stt_text_if  text_ch ();
    stt_token_if token_ch ();

    source_text_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    // The seventeen operator characters in the order of their kind codes.
    function automatic logic [7:0] op_char(input int slot);
        logic [7:0] c;
        case (slot)
            0:       c = "+";
            1:       c = "-";
            2:       c = "*";
            3:       c = "/";
            4:       c = "^";
            5:       c = "=";
            6:       c = ">";
            7:       c = "<";
            8:       c = ";";
            9:       c = ":";
            10:      c = "?";
            11:      c = ",";
            12:      c = "|";
            13:      c = "(";
            14:      c = ")";
            15:      c = "{";
            default: c = "}";
        endcase
        return c;
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z");
    endfunction

    // Tracks the scan mode, predicts the tokens of each accepted byte and
    // checks the tokens that come out against them in order.
    class token_tracker;
        mode_t  scan_state;
        token_t expected_tokens[$];
        token_t step_tokens[$];
        int     mismatches;
        int     bytes_seen;
        int     tokens_checked;

        function new();
            scan_state     = MODE_IDLE;
            mismatches     = 0;
            bytes_seen     = 0;
            tokens_checked = 0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void add_token(input logic [4:0] kind, input logic [7:0] data,
                                input logic has, input logic st, input logic sp);
            token_t t;
            t.kind     = kind;
            t.data     = data;
            t.has_byte = has;
            t.start    = st;
            t.stop     = sp;
            t.last     = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function int op_slot(input logic [7:0] b);
            for (int k = 0; k < NUM_OPERATORS; k++) begin
                if (op_char(k) == b) begin
                    return k;
                end
            end
            return -1;
        endfunction

        // A byte seen with no token open.
        function void open_from_idle(input logic [7:0] b);
            int slot;
            slot       = op_slot(b);
            scan_state = MODE_IDLE;
            if (b == CHAR_NUL || b == CHAR_SPACE || b == CHAR_LF) begin
                return;
            end
            if (is_word_char(b)) begin
                add_token(KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
                scan_state = MODE_IDENT;
            end else if (b == CHAR_QUOTE) begin
                add_token(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                scan_state = MODE_STRING;
            end else if (slot >= 0) begin
                add_token(KIND_OP_BASE + 5'(slot), b, 1'b1, 1'b1, 1'b1);
            end else begin
                add_token(KIND_ERROR, b, 1'b1, 1'b1, 1'b1);
            end
        endfunction

        function void note_byte(input logic [7:0] b);
            step_tokens.delete();
            bytes_seen++;
            case (scan_state)
                MODE_IDENT:
                begin
                    if (is_word_char(b)) begin
                        add_token(KIND_IDENT, b, 1'b1, 1'b0, 1'b0);
                    end else begin
                        add_token(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1);
                        open_from_idle(b);
                    end
                end
                MODE_STRING:
                begin
                    if (b == CHAR_QUOTE) begin
                        add_token(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1);
                        scan_state = MODE_IDLE;
                    end else if (b == CHAR_NUL) begin
                        add_token(KIND_ERROR, 8'h00, 1'b0, 1'b0, 1'b1);
                        scan_state = MODE_IDLE;
                    end else begin
                        add_token(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
                    end
                end
                default:
                begin
                    open_from_idle(b);
                end
            endcase
            if (step_tokens.size() > 0) begin
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            end
            foreach (step_tokens[i]) begin
                expected_tokens.push_back(step_tokens[i]);
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("ERROR @%0t: %s", $realtime, msg);
            end
        endtask

        task check_token(input token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("token kind %0d byte %02h with none expected",
                                          got.kind, got.data));
                return;
            end
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("token %0d: kind %0d, want %0d",
                                          tokens_checked, got.kind, want.kind));
            if (got.data !== want.data)
                report_mismatch($sformatf("token %0d: byte %02h, want %02h",
                                          tokens_checked, got.data, want.data));
            if (got.has_byte !== want.has_byte)
                report_mismatch($sformatf("token %0d: has_byte %b, want %b",
                                          tokens_checked, got.has_byte, want.has_byte));
            if (got.start !== want.start)
                report_mismatch($sformatf("token %0d: token_start %b, want %b",
                                          tokens_checked, got.start, want.start));
            if (got.stop !== want.stop)
                report_mismatch($sformatf("token %0d: token_end %b, want %b",
                                          tokens_checked, got.stop, want.stop));
            if (got.last !== want.last)
                report_mismatch($sformatf("token %0d: last_of_step %b, want %b",
                                          tokens_checked, got.last, want.last));
        endtask
    endclass

    token_tracker tracker;

    // Random gaps on each side; both are switched off for one stretch.
    bit tx_gaps_on;
    bit rx_gaps_on;
    // The stimulus asks for a long output stall by bumping stalls_asked;
    // the token side runs it and counts it off in its own process.
    int stalls_asked;
    int stalls_done;
    int stall_left;
    int cycle_count;
    int bytes_sent;

    always #2 clk = ~clk;

    initial
    begin
        tracker = new();
        clk                = 1'b0;
        rst_n              = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = 8'h00;
        token_ch.ready     = 1'b0;
        tx_gaps_on         = 1'b1;
        rx_gaps_on         = 1'b1;
        stalls_asked       = 0;
        stalls_done        = 0;
        stall_left         = 0;
        cycle_count        = 0;
        bytes_sent         = 0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d tokens still expected",
                     cycle_count, tracker.pending());
            $display("FAIL source_text_tokenizer");
            $finish;
        end
    end

    // Token side: every transfer is checked against the oldest prediction.
    // Values are sampled at the rising edge before this edge's updates, so
    // the check sees exactly what the handshake saw.
    always @(posedge clk)
    begin : token_sink
        token_t got;
        got.kind     = token_ch.token_kind;
        got.data     = token_ch.token_byte;
        got.has_byte = token_ch.has_byte;
        got.start    = token_ch.token_start;
        got.stop     = token_ch.token_end;
        got.last     = token_ch.last_of_step;
        if (rst_n && token_ch.valid && token_ch.ready) begin
            tracker.check_token(got);
        end
        if (stall_left != 0) begin
            token_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if (stalls_asked != stalls_done) begin
            token_ch.ready <= 1'b0;
            stalls_done    <= stalls_done + 1;
            stall_left     <= STALL_CYCLES;
        end else begin
            token_ch.ready <= !(rx_gaps_on && $urandom_range(99) < 34);
        end
    end

    // Offers one byte, with random gaps before it, and waits for its
    // transfer. During a gap the byte lines carry noise.
    task automatic send_byte(input logic [7:0] b);
        while (tx_gaps_on && $urandom_range(99) < 34) begin
            text_ch.valid     <= 1'b0;
            text_ch.text_byte <= 8'($urandom);
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        do begin
            @(posedge clk);
        end while (!text_ch.ready);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_word_char();
        int k;
        k = $urandom_range(61);
        if (k < 10) begin
            return 8'("0" + k);
        end else if (k < 36) begin
            return 8'("A" + k - 10);
        end
        return 8'("a" + k - 36);
    endfunction

    // A quoted string of bytes other than quote and NUL; now and then the text
    // ends inside it instead of closing it.
    task automatic send_string();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 10);
        send_byte(CHAR_QUOTE);
        repeat (n) begin
            do begin
                b = 8'($urandom_range(1, 255));
            end while (b == CHAR_QUOTE);
            send_byte(b);
        end
        send_byte(($urandom_range(9) == 0) ? CHAR_NUL : CHAR_QUOTE);
    endtask

    // One random piece of source text. Most pieces are well-formed tokens
    // with random content; the rest are separators, end-of-text marks and
    // arbitrary noise bytes.
    task automatic send_random_piece();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(random_word_char());
        end else if (pick < 48) begin
            send_string();
        end else if (pick < 68) begin
            send_byte(op_char($urandom_range(NUM_OPERATORS - 1)));
        end else if (pick < 80) begin
            send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_LF);
        end else if (pick < 85) begin
            send_byte(CHAR_NUL);
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        bit stall_sent;
        stall_sent = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. An identifier closed by the first operator gives
        // two results; then every other operator once. An identifier closed
        // by a quote opens a string holding the top byte value; an empty
        // string follows, then a string cut short by end of text. An
        // identifier closed by a line feed, an unknown high byte and end of
        // text while idle finish it.
        send_byte("A");
        for (int k = 0; k < NUM_OPERATORS; k++) begin
            send_byte(op_char(k));
        end
        send_byte("z");
        send_byte(CHAR_QUOTE);
        send_byte(8'hFF);
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_NUL);
        send_byte("9");
        send_byte(CHAR_LF);
        send_byte(8'h80);
        send_byte(CHAR_NUL);

        // Random stream. Early on the token side stalls for a long while
        // as bytes keep coming, so the result queue fills and input stalls.
        // Later, a stretch runs with no gaps on either side.
        while (bytes_sent < RANDOM_BYTES) begin
            if (!stall_sent && bytes_sent >= 500) begin
                stall_sent = 1'b1;
                stalls_asked <= stalls_asked + 1;
            end
            if (bytes_sent >= 1000 && bytes_sent < 1300) begin
                tx_gaps_on <= 1'b0;
                rx_gaps_on <= 1'b0;
            end else begin
                tx_gaps_on <= 1'b1;
                rx_gaps_on <= 1'b1;
            end
            send_random_piece();
        end
        text_ch.valid <= 1'b0;

        // Let every predicted token come out, then give the block a few
        // more cycles to show any stray result.
        while (tracker.pending() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0) begin
            tracker.report_mismatch($sformatf("%0d tokens never arrived",
                                              tracker.pending()));
        end

        $display("Run covered %0d source bytes and %0d checked tokens,",
                 tracker.bytes_seen, tracker.tokens_checked);
        $display("with a %0d-cycle output stall and a full-rate stretch; %0d mismatches.",
                 STALL_CYCLES, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("PASS source_text_tokenizer");
        end else begin
            $display("FAIL source_text_tokenizer");
        end
        $finish;
    end

endmodule
